### hdl/per_tick_emission_rate_limiter_core_assert.svh
// Assertion macros for the per-tick emission rate limiter.
// Used by the top level; the checks compile away when SYNTHESIS is set.
`ifndef PER_TICK_EMISSION_RATE_LIMITER_CORE_ASSERT_SVH
`define PER_TICK_EMISSION_RATE_LIMITER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define PETRL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Checked on every rising edge of clk_i, reset included.
`define PETRL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`else

`define PETRL_ASSERT(lbl, prop)
`define PETRL_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### hdl/petrl_pkg.sv
// Shared types, constants and helpers for the per-tick emission rate limiter.
// No dependencies; used by petrl_cfg and the top level.
package petrl_pkg;

  localparam int unsigned TickW      = 64;
  localparam int unsigned CountW     = 64;
  localparam int unsigned MaxPerTickW = 11;
  localparam int unsigned MinIntW    = 20;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 20;

  localparam logic [MaxPerTickW-1:0] MaxPerTickTop = 11'd1024;
  localparam logic [MinIntW-1:0]     MinIntervalTop = 20'd1000000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxPerTick  = 1'b0,
    CfgMinInterval = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AdmEmit     = 2'd0,
    AdmSuppress = 2'd1,
    AdmReject   = 2'd2
  } adm_e;

  typedef struct packed {
    logic [MaxPerTickW-1:0] max_per_tick;
    logic [MinIntW-1:0]     min_interval;
  } cfg_t;

  // Counter increment that sticks at all ones.
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (&v) ? v : v + {{(CountW-1){1'b0}}, 1'b1};
  endfunction

endpackage

### hdl/per_tick_emission_rate_limiter_core.sv
// Per-tick emission rate limiter, top level.
// Depends on petrl_pkg, petrl_cfg and per_tick_emission_rate_limiter_core_assert.svh.
//
// Each request on the input channel (in_valid_i / in_stall_o, payload tick_i)
// yields exactly one result on the output channel (out_valid_o / out_stall_i):
// an admission code (emit, suppressed, rejected) and the three saturating
// totals as they stand after this request.
// A request is captured in an input register; once the result slot is free,
// the decision is made against the limiter state and the result is registered.
// Throughput is one request per cycle while the receiver does not stall: the
// decision logic (a 64-bit compare, one 64-bit subtraction and one saturating
// increment) sits in one stage, and the state it updates is read back by the
// very next request.
// When the receiver stalls, the result holds and the input register keeps one
// further request; after that in_stall_o rises until the result is taken.
// Reset clears the tick history, the per-tick count and all totals, and sets
// both configuration registers to one. The user must write configuration
// through cfg_we_i / cfg_idx_i / cfg_data_i only while no request is in flight;
// the block does not enforce this. Values are clamped into their legal ranges.
`include "per_tick_emission_rate_limiter_core_assert.svh"

module per_tick_emission_rate_limiter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [petrl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [petrl_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [petrl_pkg::TickW-1:0]      tick_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       admission_o,
  output logic [petrl_pkg::CountW-1:0]     emitted_total_o,
  output logic [petrl_pkg::CountW-1:0]     suppressed_total_o,
  output logic [petrl_pkg::CountW-1:0]     rejected_total_o
);

  petrl_pkg::cfg_t cfg;

  petrl_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic                                 in_vld_q, in_vld_d;
  logic [petrl_pkg::TickW-1:0]          tick_q;
  logic                                 out_vld_q, out_vld_d;
  petrl_pkg::adm_e                      adm_q, adm_d;
  logic [petrl_pkg::TickW-1:0]          last_seen_q, last_seen_d;
  logic [petrl_pkg::TickW-1:0]          last_emit_q, last_emit_d;
  logic [petrl_pkg::MaxPerTickW-1:0]    cnt_q, cnt_d;
  logic [petrl_pkg::CountW-1:0]         emit_cnt_q, emit_cnt_d;
  logic [petrl_pkg::CountW-1:0]         sup_cnt_q, sup_cnt_d;
  logic [petrl_pkg::CountW-1:0]         rej_cnt_q, rej_cnt_d;

  logic                                 fire, in_acc;
  logic                                 reject, too_soon, cap_hit;
  logic [petrl_pkg::MaxPerTickW-1:0]    cnt_eff;
  logic [petrl_pkg::TickW-1:0]          diff;

  // The decision fires when a request is held and the result slot is free or
  // being emptied in this cycle.
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    reject  = (tick_q == '0) || (tick_q < last_seen_q);
    cnt_eff = (tick_q != last_seen_q) ? '0 : cnt_q;
    diff    = tick_q - last_emit_q;
    // The distance is at least zero here since last_emit never exceeds last_seen.
    too_soon = (last_emit_q != '0) && (tick_q != last_emit_q) &&
               (diff[petrl_pkg::TickW-1:petrl_pkg::MinIntW] == '0) &&
               (diff[petrl_pkg::MinIntW-1:0] < cfg.min_interval);
    cap_hit = cnt_eff >= cfg.max_per_tick;
  end

  always_comb begin
    in_vld_d    = in_acc ? 1'b1 : (fire ? 1'b0 : in_vld_q);
    out_vld_d   = fire || (out_vld_q && out_stall_i);
    adm_d       = adm_q;
    last_seen_d = last_seen_q;
    last_emit_d = last_emit_q;
    cnt_d       = cnt_q;
    emit_cnt_d  = emit_cnt_q;
    sup_cnt_d   = sup_cnt_q;
    rej_cnt_d   = rej_cnt_q;
    if (fire) begin
      if (reject) begin
        adm_d     = petrl_pkg::AdmReject;
        rej_cnt_d = petrl_pkg::sat_inc(rej_cnt_q);
      end else begin
        last_seen_d = tick_q;
        if (too_soon || cap_hit) begin
          adm_d     = petrl_pkg::AdmSuppress;
          cnt_d     = cnt_eff;
          sup_cnt_d = petrl_pkg::sat_inc(sup_cnt_q);
        end else begin
          adm_d       = petrl_pkg::AdmEmit;
          cnt_d       = cnt_eff + {{(petrl_pkg::MaxPerTickW-1){1'b0}}, 1'b1};
          last_emit_d = tick_q;
          emit_cnt_d  = petrl_pkg::sat_inc(emit_cnt_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      adm_q       <= petrl_pkg::AdmEmit;
      last_seen_q <= '0;
      last_emit_q <= '0;
      cnt_q       <= '0;
      emit_cnt_q  <= '0;
      sup_cnt_q   <= '0;
      rej_cnt_q   <= '0;
    end else begin
      in_vld_q    <= in_vld_d;
      out_vld_q   <= out_vld_d;
      adm_q       <= adm_d;
      last_seen_q <= last_seen_d;
      last_emit_q <= last_emit_d;
      cnt_q       <= cnt_d;
      emit_cnt_q  <= emit_cnt_d;
      sup_cnt_q   <= sup_cnt_d;
      rej_cnt_q   <= rej_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tick_q <= tick_i;
    end
  end

  // The totals only move on a decision, which needs a free or emptying result
  // slot, so the counters serve directly as the result fields.
  assign out_valid_o        = out_vld_q;
  assign admission_o        = adm_q;
  assign emitted_total_o    = emit_cnt_q;
  assign suppressed_total_o = sup_cnt_q;
  assign rejected_total_o   = rej_cnt_q;

  `PETRL_ASSERT(a_cnt_bounded, cnt_q <= petrl_pkg::MaxPerTickTop)
  `PETRL_ASSERT(a_emit_records_tick,
    (fire && !reject && !too_soon && !cap_hit) |=> (last_emit_q == $past(tick_q)))
  `PETRL_ASSERT(a_emit_before_seen, last_emit_q <= last_seen_q)
  `PETRL_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> in_vld_q)

endmodule

### hdl/petrl_cfg.sv
// Configuration registers of the rate limiter, with range clamping on write.
// Depends on petrl_pkg.
module petrl_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [petrl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [petrl_pkg::CfgDataW-1:0]  cfg_data_i,
  output petrl_pkg::cfg_t                 cfg_o
);

  logic [petrl_pkg::MaxPerTickW-1:0] max_per_tick_q, max_per_tick_d;
  logic [petrl_pkg::MinIntW-1:0]     min_interval_q, min_interval_d;
  logic [petrl_pkg::MaxPerTickW-1:0] cap_wr;
  logic [petrl_pkg::MinIntW-1:0]     int_wr;

  // Zero becomes one; anything above the top becomes the top.
  always_comb begin
    cap_wr = cfg_data_i[petrl_pkg::MaxPerTickW-1:0];
    if (cap_wr == '0) begin
      cap_wr = {{(petrl_pkg::MaxPerTickW-1){1'b0}}, 1'b1};
    end else if (cap_wr > petrl_pkg::MaxPerTickTop) begin
      cap_wr = petrl_pkg::MaxPerTickTop;
    end
    int_wr = cfg_data_i[petrl_pkg::MinIntW-1:0];
    if (int_wr == '0) begin
      int_wr = {{(petrl_pkg::MinIntW-1){1'b0}}, 1'b1};
    end else if (int_wr > petrl_pkg::MinIntervalTop) begin
      int_wr = petrl_pkg::MinIntervalTop;
    end
  end

  always_comb begin
    max_per_tick_d = max_per_tick_q;
    min_interval_d = min_interval_q;
    if (cfg_we_i) begin
      unique case (petrl_pkg::cfg_idx_e'(cfg_idx_i))
        petrl_pkg::CfgMaxPerTick:  max_per_tick_d = cap_wr;
        petrl_pkg::CfgMinInterval: min_interval_d = int_wr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_per_tick_q <= {{(petrl_pkg::MaxPerTickW-1){1'b0}}, 1'b1};
      min_interval_q <= {{(petrl_pkg::MinIntW-1){1'b0}}, 1'b1};
    end else begin
      max_per_tick_q <= max_per_tick_d;
      min_interval_q <= min_interval_d;
    end
  end

  assign cfg_o.max_per_tick = max_per_tick_q;
  assign cfg_o.min_interval = min_interval_q;

endmodule

### test/tb_top.sv
// Self-checking testbench for per_tick_emission_rate_limiter_core.
// Depends on petrl_pkg and the core RTL. Directed rows run first, tail rows last, and
// random phases under changing limits between, checked against a local predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PhaseItems = 235;
  localparam logic [63:0] RandomCeiling = 64'h4000_0000_0000_0000;

  typedef struct packed {
    petrl_pkg::adm_e              adm;
    logic [petrl_pkg::CountW-1:0] emitted;
    logic [petrl_pkg::CountW-1:0] suppressed;
    logic [petrl_pkg::CountW-1:0] rejected;
  } verdict_t;

  typedef struct {
    bit                             setting;
    bit                             tail;
    petrl_pkg::cfg_idx_e            idx;
    logic [petrl_pkg::CfgDataW-1:0] data;
    logic [petrl_pkg::TickW-1:0]    tick;
    petrl_pkg::adm_e                adm;
  } drill_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  petrl_pkg::cfg_idx_e            cfg_idx_i = petrl_pkg::CfgMaxPerTick;
  logic [petrl_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [petrl_pkg::TickW-1:0]    tick_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [1:0]                     admission_o;
  logic [petrl_pkg::CountW-1:0]   emitted_total_o;
  logic [petrl_pkg::CountW-1:0]   suppressed_total_o;
  logic [petrl_pkg::CountW-1:0]   rejected_total_o;

  per_tick_emission_rate_limiter_core i_dut (.*);

  // Predictor state: limits and tick history as the core should hold them.
  logic [petrl_pkg::MaxPerTickW-1:0] cap = 11'd1;
  logic [petrl_pkg::MinIntW-1:0]     spacing = 20'd1;
  logic [petrl_pkg::TickW-1:0]       seen_tick = '0;
  logic [petrl_pkg::MaxPerTickW-1:0] tick_emits = '0;
  logic [petrl_pkg::TickW-1:0]       emit_tick = '0;
  logic [petrl_pkg::CountW-1:0]      n_emit = '0;
  logic [petrl_pkg::CountW-1:0]      n_supp = '0;
  logic [petrl_pkg::CountW-1:0]      n_rej = '0;

  verdict_t    pending_verdicts[$];
  drill_row_t  drill[$];
  int unsigned idle_pct = 15;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("per_tick_emission_rate_limiter_core test failed");
      $finish;
    end
  end

  function automatic logic [petrl_pkg::CountW-1:0] sat_bump(
      input logic [petrl_pkg::CountW-1:0] v);
    return (v == '1) ? v : v + 64'd1;
  endfunction

  function automatic drill_row_t ask(input logic [petrl_pkg::TickW-1:0] t,
                                     input petrl_pkg::adm_e a,
                                     input bit tail = 1'b0);
    drill_row_t row;
    row = '{setting: 1'b0, tail: tail, idx: petrl_pkg::CfgMaxPerTick, data: '0,
            tick: t, adm: a};
    return row;
  endfunction

  function automatic drill_row_t put_setting(input petrl_pkg::cfg_idx_e idx,
                                             input logic [petrl_pkg::CfgDataW-1:0] data,
                                             input bit tail = 1'b0);
    drill_row_t row;
    row = '{setting: 1'b1, tail: tail, idx: idx, data: data, tick: '0,
            adm: petrl_pkg::AdmEmit};
    return row;
  endfunction

  // Register writes keep only the register's own width, then clamp into range.
  task automatic apply_setting(input petrl_pkg::cfg_idx_e idx,
                               input logic [petrl_pkg::CfgDataW-1:0] data);
    logic [petrl_pkg::MaxPerTickW-1:0] c;
    logic [petrl_pkg::MinIntW-1:0]     g;
    case (idx)
      petrl_pkg::CfgMaxPerTick: begin
        c = data[petrl_pkg::MaxPerTickW-1:0];
        cap = (c == '0) ? 11'd1 :
              (c > petrl_pkg::MaxPerTickTop) ? petrl_pkg::MaxPerTickTop : c;
      end
      petrl_pkg::CfgMinInterval: begin
        g = data[petrl_pkg::MinIntW-1:0];
        spacing = (g == '0) ? 20'd1 :
                  (g > petrl_pkg::MinIntervalTop) ? petrl_pkg::MinIntervalTop : g;
      end
      default: ;
    endcase
  endtask

  task automatic judge_request(input logic [petrl_pkg::TickW-1:0] t, output verdict_t v);
    bit too_soon;
    if (t == '0 || t < seen_tick) begin
      n_rej = sat_bump(n_rej);
      v.adm = petrl_pkg::AdmReject;
    end else begin
      if (t != seen_tick) begin
        seen_tick = t;
        tick_emits = '0;
      end
      // The spacing rule only applies between emissions at different ticks.
      too_soon = emit_tick != '0 && t != emit_tick && (t - emit_tick) < 64'(spacing);
      if (too_soon || tick_emits >= cap) begin
        n_supp = sat_bump(n_supp);
        v.adm = petrl_pkg::AdmSuppress;
      end else begin
        tick_emits = tick_emits + 11'd1;
        emit_tick = t;
        n_emit = sat_bump(n_emit);
        v.adm = petrl_pkg::AdmEmit;
      end
    end
    v.emitted = n_emit;
    v.suppressed = n_supp;
    v.rejected = n_rej;
  endtask

  task automatic push_request(input logic [petrl_pkg::TickW-1:0] t, input bit typed,
                              input petrl_pkg::adm_e a);
    verdict_t v;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    judge_request(t, v);
    if (typed) v.adm = a;
    pending_verdicts.push_back(v);
  endtask

  // Limits change only once every outstanding request has been answered.
  task automatic write_setting(input petrl_pkg::cfg_idx_e idx,
                               input logic [petrl_pkg::CfgDataW-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_setting(idx, data);
  endtask

  task automatic run_drill(input bit tail);
    foreach (drill[i]) begin
      if (drill[i].tail == tail) begin
        if (drill[i].setting) write_setting(drill[i].idx, drill[i].data);
        else push_request(drill[i].tick, 1'b1, drill[i].adm);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding");
      end else begin
        want = pending_verdicts.pop_front();
        check_field("admission", 64'(want.adm), 64'(admission_o));
        check_field("emitted_total", want.emitted, emitted_total_o);
        check_field("suppressed_total", want.suppressed, suppressed_total_o);
        check_field("rejected_total", want.rejected, rejected_total_o);
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < idle_pct);
  end

  initial begin
    logic [petrl_pkg::TickW-1:0] t;
    logic [petrl_pkg::TickW-1:0] step;
    int unsigned                 r;

    // Limits start at one each: one emission per tick, any tick distance.
    drill.push_back(ask(64'd0, petrl_pkg::AdmReject));
    drill.push_back(ask(64'd5, petrl_pkg::AdmEmit));
    drill.push_back(ask(64'd5, petrl_pkg::AdmSuppress));
    drill.push_back(ask(64'd3, petrl_pkg::AdmReject));
    drill.push_back(ask(64'd6, petrl_pkg::AdmEmit));
    drill.push_back(put_setting(petrl_pkg::CfgMaxPerTick, 20'd4));
    drill.push_back(put_setting(petrl_pkg::CfgMinInterval, 20'd3));
    drill.push_back(ask(64'd7, petrl_pkg::AdmSuppress));
    drill.push_back(ask(64'd9, petrl_pkg::AdmEmit));
    drill.push_back(ask(64'd9, petrl_pkg::AdmEmit));
    drill.push_back(ask(64'd9, petrl_pkg::AdmEmit));
    drill.push_back(ask(64'd9, petrl_pkg::AdmEmit));
    drill.push_back(ask(64'd9, petrl_pkg::AdmSuppress));
    // A cap written as zero becomes one, below the count already reached.
    drill.push_back(put_setting(petrl_pkg::CfgMaxPerTick, 20'd0));
    drill.push_back(ask(64'd9, petrl_pkg::AdmSuppress));
    drill.push_back(put_setting(petrl_pkg::CfgMaxPerTick, 20'h007FF));
    drill.push_back(put_setting(petrl_pkg::CfgMinInterval, 20'hFFFFF));
    drill.push_back(ask(64'd10, petrl_pkg::AdmSuppress));
    drill.push_back(ask(64'd1000008, petrl_pkg::AdmSuppress));
    drill.push_back(ask(64'd1000009, petrl_pkg::AdmEmit));
    drill.push_back(put_setting(petrl_pkg::CfgMinInterval, 20'd0));
    drill.push_back(put_setting(petrl_pkg::CfgMaxPerTick, 20'hFF802));
    drill.push_back(ask(64'd1000009, petrl_pkg::AdmEmit));
    drill.push_back(ask(64'd1000009, petrl_pkg::AdmSuppress));
    drill.push_back(ask(64'd1000010, petrl_pkg::AdmEmit));
    drill.push_back(put_setting(petrl_pkg::CfgMaxPerTick, 20'd1024));
    drill.push_back(put_setting(petrl_pkg::CfgMinInterval, 20'd1000000));
    drill.push_back(ask(64'd1000011, petrl_pkg::AdmSuppress));
    drill.push_back(ask(64'd2000010, petrl_pkg::AdmEmit));
    // The top of the tick range is left for the very end, since nothing can follow it.
    drill.push_back(put_setting(petrl_pkg::CfgMaxPerTick, 20'd1, 1'b1));
    drill.push_back(put_setting(petrl_pkg::CfgMinInterval, 20'd1, 1'b1));
    drill.push_back(ask(64'h8000_0000_0000_0000, petrl_pkg::AdmEmit, 1'b1));
    drill.push_back(ask(64'hFFFF_FFFF_FFFF_FFFE, petrl_pkg::AdmEmit, 1'b1));
    drill.push_back(ask(64'hFFFF_FFFF_FFFF_FFFF, petrl_pkg::AdmEmit, 1'b1));
    drill.push_back(ask(64'hFFFF_FFFF_FFFF_FFFF, petrl_pkg::AdmSuppress, 1'b1));
    drill.push_back(ask(64'h7FFF_FFFF_FFFF_FFFF, petrl_pkg::AdmReject, 1'b1));
    drill.push_back(ask(64'd0, petrl_pkg::AdmReject, 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_drill(1'b0);

    for (int p = 0; p < PhaseCount; p++) begin
      r = $urandom_range(0, 9);
      write_setting(petrl_pkg::CfgMaxPerTick,
                    (r == 0) ? 20'd0 :
                    (r == 1) ? 20'($urandom_range(0, 20'hFFFFF)) :
                    (r == 2) ? 20'd1024 : 20'($urandom_range(1, 6)));
      r = $urandom_range(0, 9);
      write_setting(petrl_pkg::CfgMinInterval,
                    (r == 0) ? 20'd0 :
                    (r == 1) ? 20'hFFFFF :
                    (r == 2) ? 20'($urandom_range(1, 1000000)) :
                    20'($urandom_range(1, 12)));
      idle_pct = (p == 3) ? 0 : 15;
      for (int i = 0; i < PhaseItems; i++) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          t = '0;
        end else if (r < 10) begin
          t = (seen_tick > 64'd1) ? {$urandom, $urandom} % seen_tick : '0;
        end else if (r < 45) begin
          t = (seen_tick == '0) ? 64'd1 : seen_tick;
        end else if (r < 92) begin
          t = seen_tick + 64'($urandom_range(1, 2 * spacing + 2));
        end else begin
          step = {$urandom, $urandom} >> $urandom_range(8, 63);
          if (step == '0 || seen_tick + step >= RandomCeiling) step = 64'd1;
          t = seen_tick + step;
        end
        push_request(t, 1'b0, petrl_pkg::AdmEmit);
      end
    end
    idle_pct = 15;

    run_drill(1'b1);
    in_valid_i <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("per_tick_emission_rate_limiter_core test passed");
    end else begin
      $display("per_tick_emission_rate_limiter_core test failed");
    end
    $finish;
  end

endmodule
